/* src/swhc_pkg.sv */
// shared types and constants for the sliding window hit counter
package swhc_pkg;

    localparam int unsigned STORE_DEPTH_DEFAULT = 512;

    localparam int unsigned TIME_W   = 31;
    localparam int unsigned HITS_W   = 16;
    localparam int unsigned WINDOW_W = 10;
    localparam int unsigned TOTAL_W  = 32;
    localparam int unsigned ENTRY_W  = TIME_W + HITS_W;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(300);
    localparam logic [HITS_W-1:0]   HITS_MAX     = '1;
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = '1;

    // operation codes
    typedef enum logic {
        OP_HIT   = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVICT,
        ST_RESULT
    } state_t;

    // write request into the entry store
    typedef struct packed {
        logic               en;
        logic [TIME_W-1:0]  time_val;
        logic [HITS_W-1:0]  hits;
    } store_wr_t;

endpackage

/* src/sliding_window_hit_counter_top.sv */
// top level of the sliding window hit counter: sequencer, pointers and total
//
// Usage: each request on the input channel carries an operation (hit or query)
// and a timestamp in seconds that never decreases. A hit records one event at
// that time; a query returns on the output channel the number of hits whose
// age is below window_seconds. Hits return nothing.
// The window register is written through its own valid/ready channel, which is
// always ready; write it only while the block is idle.
// Sequence: a request is accepted in the idle state, then the evict state
// removes expired entries from the oldest end one at a time, and then it
// finishes the request. Each entry expires only once. The removal loop reads
// one entry per cycle from the store read port and that port sets the rate.
// Query results sit in an output register; the next request is accepted
// while a result waits, and a following query holds in a wait state until
// the receiver takes the earlier result.
// Reset empties the store (no clearing pass: only occupied entries are read),
// clears the total and sets the window to 300.
module sliding_window_hit_counter_top
    import swhc_pkg::*;
#(
    parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEFAULT,
    localparam int unsigned PTR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1,
    localparam int unsigned OCC_W = $clog2(STORE_DEPTH + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                operation,
    input  logic [TIME_W-1:0]   timestamp,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [TOTAL_W-1:0]  hit_count,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [WINDOW_W-1:0] window_seconds
);

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(STORE_DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_FULL  = OCC_W'(STORE_DEPTH);

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [WINDOW_W-1:0] window_reg;
    logic [PTR_W-1:0]    oldest_reg, oldest_next;
    logic [PTR_W-1:0]    newest_reg, newest_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [TIME_W-1:0]   newest_time_reg, newest_time_next;
    logic [HITS_W-1:0]   newest_hits_reg, newest_hits_next;
    logic                out_valid_reg, out_valid_next;
    logic [TOTAL_W-1:0]  hit_count_reg, hit_count_next;

    store_wr_t           wr;
    logic [PTR_W-1:0]    wr_addr;
    logic [PTR_W-1:0]    rd_addr;
    logic [TIME_W-1:0]   rd_time;
    logic [HITS_W-1:0]   rd_hits;

    logic [TIME_W-1:0]   age;
    logic                expired;
    logic                out_free;
    logic [TOTAL_W-1:0]  total_dropped;
    logic [PTR_W-1:0]    oldest_inc;
    logic [PTR_W-1:0]    newest_inc;

    swhc_store #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr      (wr),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .rd_time (rd_time),
        .rd_hits (rd_hits)
    );

    // shared age compare against the oldest entry
    assign age     = now_reg - rd_time;
    assign expired = (occ_reg != '0) && (now_reg >= rd_time)
                     && (age >= TIME_W'(window_reg));

    assign oldest_inc    = (oldest_reg == LAST_SLOT) ? '0 : oldest_reg + PTR_W'(1);
    assign newest_inc    = (newest_reg == LAST_SLOT) ? '0 : newest_reg + PTR_W'(1);
    assign total_dropped = (total_reg >= TOTAL_W'(rd_hits)) ? total_reg - TOTAL_W'(rd_hits)
                                                           : '0;
    assign out_free      = !out_valid_reg || out_ready;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign hit_count = hit_count_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= WINDOW_RESET;
            oldest_reg    <= '0;
            newest_reg    <= '0;
            occ_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            newest_reg    <= newest_next;
            occ_reg       <= occ_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                window_reg <= window_seconds;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        now_reg         <= now_next;
        newest_time_reg <= newest_time_next;
        newest_hits_reg <= newest_hits_next;
        hit_count_reg   <= hit_count_next;
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        now_next         = now_reg;
        oldest_next      = oldest_reg;
        newest_next      = newest_reg;
        occ_next         = occ_reg;
        total_next       = total_reg;
        newest_time_next = newest_time_reg;
        newest_hits_next = newest_hits_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        hit_count_next   = hit_count_reg;
        rd_addr          = oldest_reg;
        wr_addr          = newest_reg;
        wr               = '{en: 1'b0, time_val: now_reg, hits: HITS_W'(1)};

        case (state_reg)
            ST_IDLE:
            begin
                // read of the oldest entry is already in flight
                if (in_valid)
                begin
                    op_next    = op_t'(operation);
                    now_next   = timestamp;
                    state_next = ST_EVICT;
                end
            end

            ST_EVICT:
            begin
                if (expired)
                begin
                    // drop the oldest entry and fetch the next one
                    total_next  = total_dropped;
                    oldest_next = oldest_inc;
                    occ_next    = occ_reg - OCC_W'(1);
                    rd_addr     = oldest_inc;
                end
                else if (op_reg == OP_QUERY)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        hit_count_next = total_reg;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
                else if ((occ_reg != '0) && (newest_time_reg == now_reg))
                begin
                    // same second as the newest entry: bump its count
                    if (newest_hits_reg != HITS_MAX)
                    begin
                        newest_hits_next = newest_hits_reg + HITS_W'(1);
                        wr.en            = 1'b1;
                        wr.time_val      = newest_time_reg;
                        wr.hits          = newest_hits_reg + HITS_W'(1);
                        if (total_reg != TOTAL_MAX)
                        begin
                            total_next = total_reg + TOTAL_W'(1);
                        end
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    // append a new entry, dropping the oldest when full
                    if (occ_reg == OCC_FULL)
                    begin
                        oldest_next = oldest_inc;
                        total_next  = (total_dropped != TOTAL_MAX)
                                      ? total_dropped + TOTAL_W'(1) : total_dropped;
                    end
                    else
                    begin
                        occ_next   = occ_reg + OCC_W'(1);
                        total_next = (total_reg != TOTAL_MAX)
                                     ? total_reg + TOTAL_W'(1) : total_reg;
                    end
                    newest_next      = (occ_reg == '0) ? oldest_reg : newest_inc;
                    wr_addr          = newest_next;
                    wr.en            = 1'b1;
                    newest_time_next = now_reg;
                    newest_hits_next = HITS_W'(1);
                    state_next       = ST_IDLE;
                end
            end

            ST_RESULT:
            begin
                // wait for the earlier result to leave
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    hit_count_next = total_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // occupancy never passes the store depth
    assert property (@(posedge clk) disable iff (!rst_n) occ_reg <= OCC_FULL)
        else $error("occupancy beyond store depth");

    // a finished hit always leaves at least one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVICT && op_reg == OP_HIT && !expired) |=> (occ_reg != '0))
        else $error("store empty after a hit");

    // a new result only comes from a query
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg || out_ready) && out_valid_next |-> (op_reg == OP_QUERY))
        else $error("result produced by a hit");

    // input is never taken while expired entries are being removed
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVICT && expired) |=> !in_ready)
        else $error("input accepted during eviction");

endmodule

/* src/swhc_store.sv */
// entry store: one write port, one read port with registered read data
module swhc_store
    import swhc_pkg::*;
#(
    parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEFAULT,
    localparam int unsigned PTR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
)
(
    input  logic               clk,
    input  store_wr_t          wr,
    input  logic [PTR_W-1:0]   wr_addr,
    input  logic [PTR_W-1:0]   rd_addr,
    output logic [TIME_W-1:0]  rd_time,
    output logic [HITS_W-1:0]  rd_hits
);

    logic [ENTRY_W-1:0] mem [STORE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= {wr.time_val, wr.hits};
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_time = rd_data_reg[ENTRY_W-1:HITS_W];
    assign rd_hits = rd_data_reg[HITS_W-1:0];

endmodule
